[src/mpeg_audio_header_decode_core_assert.svh]
// Assertion macros for the MPEG audio header decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MPEG_AUDIO_HEADER_DECODE_CORE_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODE_CORE_ASSERT_SVH

// same-cycle implication
`define MAHD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mahd assertion failed");

// next-cycle implication
`define MAHD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mahd assertion failed");

`endif

[src/mahd_pkg.sv]
// Shared types, status codes and the layer III frame size table.
// No dependencies.
package mahd_pkg;

	typedef enum logic [2:0] {
		ST_OK_L3     = 3'd0,
		ST_OK_L12    = 3'd1,
		ST_BAD_RATE  = 3'd2,
		ST_FREE      = 3'd3,
		ST_BAD_LAYER = 3'd4,
		ST_BAD_BRATE = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		VER_MPEG1  = 2'd0,
		VER_MPEG2  = 2'd1,
		VER_MPEG25 = 2'd2
	} version_t;

	localparam int RATE_CNT = 9;

	typedef struct packed {
		status_t     status;
		version_t    version;
		logic [2:0]  layer;
		logic [3:0]  rate_index;
		logic        crc_present;
		logic [3:0]  bitrate_code;
		logic        padding;
		logic [1:0]  channel_mode;
		logic [1:0]  mode_extension;
		logic [2:0]  misc_flags;
		logic [1:0]  emphasis;
	} hdr_fields_t;

	// kbps * 144000 / (rate << lsf), truncated; rows by rate index, columns by bitrate code
	localparam logic [10:0] FRAME_QUOT [RATE_CNT][16] = '{
		'{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
		  11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
		'{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
		  11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
		'{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
		  11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0},
		'{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
		  11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
		'{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
		  11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
		'{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
		  11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0},
		'{11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
		  11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0},
		'{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
		  11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0},
		'{11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
		  11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0}
	};

endpackage

[src/mahd_unpack.sv]
// Header word unpacking, version and rate index resolution, status priority.
// Depends on mahd_pkg.
module mahd_unpack (
	input  logic [31:0]          header_word,
	output mahd_pkg::hdr_fields_t fields
);

	logic [1:0] rcode;
	logic [3:0] brc;
	logic [2:0] lyr;
	logic [3:0] roff;

	always_comb begin
		rcode = header_word[11:10];
		brc   = header_word[15:12];
		lyr   = 3'd4 - {1'b0, header_word[18:17]};

		if (header_word[20]) begin
			fields.version = header_word[19] ? mahd_pkg::VER_MPEG1 : mahd_pkg::VER_MPEG2;
		end else begin
			fields.version = mahd_pkg::VER_MPEG25;
		end

		case (fields.version)
			mahd_pkg::VER_MPEG1: roff = 4'd0;
			mahd_pkg::VER_MPEG2: roff = 4'd3;
			default:             roff = 4'd6;
		endcase

		fields.layer          = lyr;
		fields.crc_present    = ~header_word[16];
		fields.bitrate_code   = brc;
		fields.padding        = header_word[9];
		fields.channel_mode   = header_word[7:6];
		fields.mode_extension = header_word[5:4];
		fields.misc_flags     = {header_word[8], header_word[3], header_word[2]};
		fields.emphasis       = header_word[1:0];

		if (rcode == 2'd3) begin
			fields.rate_index = 4'd0;
			fields.status     = mahd_pkg::ST_BAD_RATE;
		end else begin
			fields.rate_index = {2'b00, rcode} + roff;
			if (brc == 4'd0) begin
				fields.status = mahd_pkg::ST_FREE;
			end else if (brc == 4'd15) begin
				fields.status = mahd_pkg::ST_BAD_BRATE;
			end else if (lyr == 3'd4) begin
				fields.status = mahd_pkg::ST_BAD_LAYER;
			end else if (lyr == 3'd3) begin
				fields.status = mahd_pkg::ST_OK_L3;
			end else begin
				fields.status = mahd_pkg::ST_OK_L12;
			end
		end
	end

endmodule

[src/mahd_size.sv]
// Layer III frame size quotient lookup from rate index and bitrate code.
// Depends on mahd_pkg.
module mahd_size (
	input  mahd_pkg::hdr_fields_t fields,
	output logic [10:0]           quot
);

	always_comb begin
		if (fields.status == mahd_pkg::ST_OK_L3 && fields.rate_index < 4'(mahd_pkg::RATE_CNT)) begin
			quot = mahd_pkg::FRAME_QUOT[fields.rate_index][fields.bitrate_code];
		end else begin
			quot = 11'd0;
		end
	end

endmodule

[src/mpeg_audio_header_decode_core.sv]
// MPEG audio frame header decoder, top level: four-stage pipeline and handshake.
// Depends on mahd_pkg, mahd_unpack, mahd_size and the assertion macro header.
//
//   channel | signals                      | request
//   --------+------------------------------+-------------------------------
//   header  | hdr_valid, hdr_stall         | header_word
//   result  | res_valid, res_stall         | status .. frame_bytes
//
// One request enters per cycle unless a stall holds the pipeline; each result passes through the stages in order.
// Stages: input register, unpack and status, size table lookup, byte count adjust.
// A stage advances when it is empty or the stage after it advances; a stall
// holds the last stage and every full stage directly behind it; nothing is dropped or repeated.
// Reset empties all stages; no clearing pass is needed.
`include "mpeg_audio_header_decode_core_assert.svh"

module mpeg_audio_header_decode_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hdr_valid,
	output logic        hdr_stall,
	input  logic [31:0] header_word,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [1:0]  version,
	output logic [2:0]  layer,
	output logic [3:0]  rate_index,
	output logic        crc_present,
	output logic [3:0]  bitrate_code,
	output logic        padding,
	output logic [1:0]  channel_mode,
	output logic [1:0]  mode_extension,
	output logic [2:0]  misc_flags,
	output logic [1:0]  emphasis,
	output logic [10:0] frame_bytes
);

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic                  adv_s1, adv_s2, adv_s3, adv_s4;
	logic [31:0]           hdr_s1;
	mahd_pkg::hdr_fields_t fld_dec, fld_s2, fld_s3, fld_s4;
	logic [10:0]           quot_dec, quot_s3;
	logic [10:0]           bytes_s4;

	assign adv_s4    = ~vld_s4 | ~res_stall;
	assign adv_s3    = ~vld_s3 | adv_s4;
	assign adv_s2    = ~vld_s2 | adv_s3;
	assign adv_s1    = ~vld_s1 | adv_s2;
	assign hdr_stall = ~adv_s1;

	mahd_unpack u_unpack (
		.header_word (hdr_s1),
		.fields      (fld_dec)
	);

	mahd_size u_size (
		.fields (fld_s2),
		.quot   (quot_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= hdr_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && hdr_valid) begin
			hdr_s1 <= header_word;
		end
		if (adv_s2 && vld_s1) begin
			fld_s2 <= fld_dec;
		end
		if (adv_s3 && vld_s2) begin
			fld_s3  <= fld_s2;
			quot_s3 <= quot_dec;
		end
		if (adv_s4 && vld_s3) begin
			fld_s4 <= fld_s3;
			if (fld_s3.status == mahd_pkg::ST_OK_L3) begin
				bytes_s4 <= quot_s3 + {10'd0, fld_s3.padding} - 11'd4;
			end else begin
				bytes_s4 <= 11'd0;
			end
		end
	end

	assign res_valid      = vld_s4;
	assign status         = fld_s4.status;
	assign version        = fld_s4.version;
	assign layer          = fld_s4.layer;
	assign rate_index     = fld_s4.rate_index;
	assign crc_present    = fld_s4.crc_present;
	assign bitrate_code   = fld_s4.bitrate_code;
	assign padding        = fld_s4.padding;
	assign channel_mode   = fld_s4.channel_mode;
	assign mode_extension = fld_s4.mode_extension;
	assign misc_flags     = fld_s4.misc_flags;
	assign emphasis       = fld_s4.emphasis;
	assign frame_bytes    = bytes_s4;

	`MAHD_ASSERT_NEXT(a_accept_fills_s1, hdr_valid && !hdr_stall, vld_s1)
	`MAHD_ASSERT_NOW(a_err_no_size, res_valid && status != mahd_pkg::ST_OK_L3, frame_bytes == 11'd0)
	`MAHD_ASSERT_NOW(a_l3_has_size, res_valid && status == mahd_pkg::ST_OK_L3, frame_bytes != 11'd0)
	`MAHD_ASSERT_NOW(a_bad_rate_idx, res_valid && status == mahd_pkg::ST_BAD_RATE, rate_index == 4'd0)

endmodule

[tb/mpeg_audio_header_decode_core_tb.sv]
// Self-checking testbench for mpeg_audio_header_decode_core: directed and random header words,
// each result checked field by field against a local decoder of the header bit layout.
// Depends on mahd_pkg and the decoder RTL.
module mpeg_audio_header_decode_core_tb;

	localparam int RANDOM_HEADERS = 1580;
	localparam int SLOW_SINK_END = 530;
	localparam int SLOW_SOURCE_END = 1070;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES = 8;

	localparam int PH_SLOW_SINK = 0;
	localparam int PH_SLOW_SOURCE = 1;
	localparam int PH_FULL_RATE = 2;

	localparam logic [1:0] VB_MPEG1 = 2'b11;
	localparam logic [1:0] VB_MPEG2 = 2'b10;
	localparam logic [1:0] VB_MPEG25 = 2'b00;
	localparam logic [1:0] VB_MPEG25_ALT = 2'b01;
	localparam logic [1:0] LB_RESERVED = 2'b00;
	localparam logic [1:0] LB_LAYER3 = 2'b01;
	localparam logic [1:0] LB_LAYER2 = 2'b10;
	localparam logic [1:0] LB_LAYER1 = 2'b11;
	localparam logic [1:0] RC_RESERVED = 2'd3;
	localparam logic [3:0] BRC_FREE = 4'd0;
	localparam logic [3:0] BRC_BAD = 4'hf;

	localparam int unsigned KBPS_MPEG1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
		112, 128, 160, 192, 224, 256, 320, 0};
	localparam int unsigned KBPS_LSF [16] = '{0, 8, 16, 24, 32, 40, 48, 56,
		64, 80, 96, 112, 128, 144, 160, 0};
	localparam int unsigned SAMPLE_HZ [9] = '{44100, 48000, 32000, 22050, 24000, 16000,
		11025, 12000, 8000};

	typedef struct packed {
		mahd_pkg::status_t  status;
		mahd_pkg::version_t version;
		logic [2:0]  layer;
		logic [3:0]  rate_index;
		logic        crc_present;
		logic [3:0]  bitrate_code;
		logic        padding;
		logic [1:0]  channel_mode;
		logic [1:0]  mode_extension;
		logic [2:0]  misc_flags;
		logic [1:0]  emphasis;
		logic [10:0] frame_bytes;
	} decoded_hdr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        hdr_valid = 1'b0;
	logic        hdr_stall;
	logic [31:0] header_word = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  status;
	logic [1:0]  version;
	logic [2:0]  layer;
	logic [3:0]  rate_index;
	logic        crc_present;
	logic [3:0]  bitrate_code;
	logic        padding;
	logic [1:0]  channel_mode;
	logic [1:0]  mode_extension;
	logic [2:0]  misc_flags;
	logic [1:0]  emphasis;
	logic [10:0] frame_bytes;

	logic [31:0]  pending_headers [$];
	decoded_hdr_t expected_fields [$];
	int           headers_sent = 0;
	int           results_checked = 0;
	int           mismatches = 0;
	int           directed_count = 0;
	int           status_tally [6] = '{default: 0};
	int           phase = PH_SLOW_SINK;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	int           quiet_cycles = 0;

	mpeg_audio_header_decode_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.header_word(header_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.version(version),
		.layer(layer),
		.rate_index(rate_index),
		.crc_present(crc_present),
		.bitrate_code(bitrate_code),
		.padding(padding),
		.channel_mode(channel_mode),
		.mode_extension(mode_extension),
		.misc_flags(misc_flags),
		.emphasis(emphasis),
		.frame_bytes(frame_bytes)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] make_header(logic [1:0] ver_bits, logic [1:0] layer_bits,
			logic prot, logic [3:0] brc, logic [1:0] rcode, logic pad, logic [8:0] low);
		return {11'h7ff, ver_bits, layer_bits, prot, brc, rcode, pad, low};
	endfunction

	function automatic decoded_hdr_t decode_header(logic [31:0] h);
		decoded_hdr_t d;
		logic         lsf;
		int unsigned  kbps;
		int unsigned  den;
		int unsigned  bytes;
		d = '0;
		if (h[20]) begin
			d.version = h[19] ? mahd_pkg::VER_MPEG1 : mahd_pkg::VER_MPEG2;
			lsf = !h[19];
		end else begin
			d.version = mahd_pkg::VER_MPEG25;
			lsf = 1'b1;
		end
		d.layer = 3'd4 - {1'b0, h[18:17]};
		d.crc_present = !h[16];
		d.bitrate_code = h[15:12];
		d.padding = h[9];
		d.channel_mode = h[7:6];
		d.mode_extension = h[5:4];
		d.misc_flags = {h[8], h[3], h[2]};
		d.emphasis = h[1:0];
		if (h[11:10] == RC_RESERVED) begin
			d.status = mahd_pkg::ST_BAD_RATE;
		end else begin
			case (d.version)
				mahd_pkg::VER_MPEG1: d.rate_index = {2'b00, h[11:10]};
				mahd_pkg::VER_MPEG2: d.rate_index = {2'b00, h[11:10]} + 4'd3;
				default:             d.rate_index = {2'b00, h[11:10]} + 4'd6;
			endcase
			if (d.bitrate_code == BRC_FREE) begin
				d.status = mahd_pkg::ST_FREE;
			end else if (d.bitrate_code == BRC_BAD) begin
				d.status = mahd_pkg::ST_BAD_BRATE;
			end else if (d.layer == 3'd4) begin
				d.status = mahd_pkg::ST_BAD_LAYER;
			end else if (d.layer == 3'd3) begin
				kbps = lsf ? KBPS_LSF[d.bitrate_code] : KBPS_MPEG1[d.bitrate_code];
				den = SAMPLE_HZ[d.rate_index] << lsf;
				bytes = kbps * 144000 / den + d.padding - 4;
				d.frame_bytes = bytes[10:0];
				d.status = mahd_pkg::ST_OK_L3;
			end else begin
				d.status = mahd_pkg::ST_OK_L12;
			end
		end
		return d;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		logic [1:0] ver_bits;
		logic [1:0] layer_bits;
		logic [1:0] rcode;
		logic [3:0] brc;
		int         roll;
		pending_headers.push_back(32'h0000_0000);
		pending_headers.push_back(32'hffff_ffff);
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER3, 1'b1, 4'd9, RC_RESERVED, 1'b0,
			9'h000));
		pending_headers.push_back(make_header(VB_MPEG25, LB_RESERVED, 1'b0, BRC_FREE, RC_RESERVED,
			1'b1, 9'h1ff));
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER3, 1'b1, BRC_FREE, 2'd0, 1'b0,
			9'h000));
		pending_headers.push_back(make_header(VB_MPEG1, LB_RESERVED, 1'b1, BRC_FREE, 2'd1, 1'b0,
			9'h000));
		pending_headers.push_back(make_header(VB_MPEG2, LB_LAYER3, 1'b1, BRC_BAD, 2'd2, 1'b0,
			9'h0f0));
		pending_headers.push_back(make_header(VB_MPEG1, LB_RESERVED, 1'b1, BRC_BAD, 2'd0, 1'b1,
			9'h00f));
		pending_headers.push_back(make_header(VB_MPEG1, LB_RESERVED, 1'b1, 4'd5, 2'd0, 1'b0,
			9'h100));
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER3, 1'b1, 4'd14, 2'd2, 1'b1,
			9'h1ff));
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER3, 1'b0, 4'd1, 2'd0, 1'b0,
			9'h000));
		pending_headers.push_back(make_header(VB_MPEG2, LB_LAYER3, 1'b1, 4'd1, 2'd1, 1'b0,
			9'h040));
		pending_headers.push_back(make_header(VB_MPEG2, LB_LAYER3, 1'b1, 4'd14, 2'd2, 1'b1,
			9'h080));
		pending_headers.push_back(make_header(VB_MPEG25, LB_LAYER3, 1'b1, 4'd1, 2'd0, 1'b1,
			9'h0c0));
		pending_headers.push_back(make_header(VB_MPEG25_ALT, LB_LAYER3, 1'b1, 4'd14, 2'd2, 1'b0,
			9'h030));
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER2, 1'b1, 4'd9, 2'd0, 1'b0,
			9'h008));
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER1, 1'b0, 4'd9, 2'd1, 1'b1,
			9'h004));
		pending_headers.push_back(make_header(VB_MPEG2, LB_LAYER2, 1'b1, 4'd1, 2'd2, 1'b0,
			9'h155));
		pending_headers.push_back(make_header(VB_MPEG25, LB_LAYER1, 1'b0, 4'd14, 2'd1, 1'b1,
			9'h0aa));
		pending_headers.push_back(make_header(VB_MPEG1, LB_LAYER3, 1'b1, 4'd13, 2'd1, 1'b0,
			9'h0c3));
		directed_count = pending_headers.size();

		for (int i = 0; i < RANDOM_HEADERS; i++) begin
			roll = $urandom_range(99);
			case ($urandom_range(3))
				0:       ver_bits = VB_MPEG1;
				1:       ver_bits = VB_MPEG2;
				2:       ver_bits = VB_MPEG25;
				default: ver_bits = VB_MPEG25_ALT;
			endcase
			case ($urandom_range(7))
				0:       layer_bits = LB_LAYER1;
				1:       layer_bits = LB_LAYER2;
				default: layer_bits = LB_LAYER3;
			endcase
			brc = 4'($urandom_range(14, 1));
			rcode = 2'($urandom_range(2));
			if (roll >= 70 && roll < 85) begin
				case ($urandom_range(3))
					0:       rcode = RC_RESERVED;
					1:       brc = BRC_FREE;
					2:       brc = BRC_BAD;
					default: layer_bits = LB_RESERVED;
				endcase
			end
			if (roll >= 85)
				pending_headers.push_back($urandom);
			else
				pending_headers.push_back(make_header(ver_bits, layer_bits,
					1'($urandom_range(1)), brc, rcode, 1'($urandom_range(1)),
					9'($urandom_range(511))));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_headers.size() != 0 || hdr_valid || expected_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d headers (%0d directed), %0d results checked, %0d mismatches",
			headers_sent, directed_count, results_checked, mismatches);
		$display("status hits: ok3 %0d, ok12 %0d, rate %0d, free %0d, layer %0d, bitrate %0d",
			status_tally[mahd_pkg::ST_OK_L3], status_tally[mahd_pkg::ST_OK_L12],
			status_tally[mahd_pkg::ST_BAD_RATE], status_tally[mahd_pkg::ST_FREE],
			status_tally[mahd_pkg::ST_BAD_LAYER], status_tally[mahd_pkg::ST_BAD_BRATE]);
		if (mismatches == 0 && expected_fields.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		int         idle_pct;
		decoded_hdr_t d;
		if (!arst_n) begin
			hdr_valid <= 1'b0;
			header_word <= '0;
		end else begin
			if (hdr_valid && !hdr_stall) begin
				d = decode_header(header_word);
				expected_fields.push_back(d);
				status_tally[d.status]++;
				headers_sent++;
			end
			if (headers_sent < SLOW_SINK_END)
				phase <= PH_SLOW_SINK;
			else if (headers_sent < SLOW_SOURCE_END)
				phase <= PH_SLOW_SOURCE;
			else
				phase <= PH_FULL_RATE;
			case (phase)
				PH_SLOW_SINK:   idle_pct = 14;
				PH_SLOW_SOURCE: idle_pct = 83;
				default:        idle_pct = 0;
			endcase
			if (!hdr_valid || !hdr_stall) begin
				if (pending_headers.size() != 0 && $urandom_range(99) >= idle_pct) begin
					hdr_valid <= 1'b1;
					header_word <= pending_headers.pop_front();
				end else begin
					hdr_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (phase == PH_FULL_RATE && !hold_done) begin
			res_stall <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			hold_done <= 1'b1;
		end else begin
			case (phase)
				PH_SLOW_SINK:   res_stall <= $urandom_range(99) < 83;
				PH_SLOW_SOURCE: res_stall <= $urandom_range(99) < 14;
				default:        res_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		decoded_hdr_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_fields.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual status %0d", $time, status);
			end else begin
				want = expected_fields.pop_front();
				results_checked++;
				check_field("status", want.status, status);
				check_field("version", want.version, version);
				check_field("layer", want.layer, layer);
				check_field("rate_index", want.rate_index, rate_index);
				check_field("crc_present", want.crc_present, crc_present);
				check_field("bitrate_code", want.bitrate_code, bitrate_code);
				check_field("padding", want.padding, padding);
				check_field("channel_mode", want.channel_mode, channel_mode);
				check_field("mode_extension", want.mode_extension, mode_extension);
				check_field("misc_flags", want.misc_flags, misc_flags);
				check_field("emphasis", want.emphasis, emphasis);
				check_field("frame_bytes", want.frame_bytes, frame_bytes);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

[sim.f]
+incdir+src
src/mahd_pkg.sv
src/mahd_unpack.sv
src/mahd_size.sv
src/mpeg_audio_header_decode_core.sv
tb/mpeg_audio_header_decode_core_tb.sv
